### hdl/sdrf_pkg.sv
`default_nettype none
package sdrf_pkg;

	// Default grid limits.
	localparam int DEF_MAX_X = 64;
	localparam int DEF_MAX_Y = 64;
	localparam int DEF_MAX_Z = 64;

	// Field and register widths.
	localparam int SAMPLE_W   = 24;
	localparam int COORD_W    = 6;
	localparam int COUNT_W    = 19;
	localparam int DIM_W      = 7;
	localparam int RANK_W     = 2;
	localparam int GW_W       = 4;
	localparam int WEIGHT_W   = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int STRIDE_W   = 2 * DIM_W;

	// Job queue between the front and back parts.
	localparam int QDEPTH = 4;
	localparam int QPTR_W = 2;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_DIM_X     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DIM_Y     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DIM_Z     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RANK      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_GHOST     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_EPSILON   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd6;

	// Register reset values.
	localparam logic [DIM_W-1:0]    RST_DIM       = 7'd64;
	localparam logic [RANK_W-1:0]   RST_RANK      = 2'd3;
	localparam logic [GW_W-1:0]     RST_GHOST     = 4'd3;
	localparam logic [WEIGHT_W-1:0] RST_EPSILON   = 16'd655;
	localparam logic [WEIGHT_W-1:0] RST_THRESHOLD = 16'd1229;

	// Grid geometry as seen by the back part.
	typedef struct packed {
		logic [RANK_W-1:0]   rk;
		logic [DIM_W-1:0]    s1;
		logic [STRIDE_W-1:0] s2;
		logic [STRIDE_W-1:0] stop;
	} geom_t;

	// Description of one active cell to be judged.
	typedef struct packed {
		logic [COORD_W-1:0] cx;
		logic [COORD_W-1:0] cy;
		logic [COORD_W-1:0] cz;
		logic               last;
		logic               fresh;
	} job_t;

	// Queue status.
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage
`default_nettype wire

### hdl/sdrf_ram.sv
`default_nettype none
module sdrf_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 16385,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port, one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

### hdl/sdrf_queue.sv
`default_nettype none
module sdrf_queue #(
	parameter int W = 32
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire logic [W-1:0]    push_data,
	input  wire logic            pop,
	output logic      [W-1:0]    head,
	output sdrf_pkg::q_stat_t    stat
);
	import sdrf_pkg::*;

	logic [W-1:0]      entry_q [QDEPTH];
	logic [QPTR_W-1:0] wptr_q;
	logic [QPTR_W-1:0] rptr_q;
	logic [QPTR_W:0]   count_q;

	assign head       = entry_q[rptr_q];
	assign stat.full  = (count_q == (QPTR_W + 1)'(QDEPTH));
	assign stat.empty = (count_q == '0);

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wptr_q] <= push_data;
		end
	end

endmodule
`default_nettype wire

### hdl/sdrf_front.sv
`default_nettype none
module sdrf_front #(
	parameter int MAX_X = 64,
	parameter int MAX_Y = 64,
	parameter int MAX_Z = 64,
	localparam int DEPTH = 4 * MAX_X * MAX_Y + 1,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_we,
	input  wire logic [sdrf_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [sdrf_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  wire logic                               in_valid,
	output logic                                    in_stall,
	input  wire logic signed [sdrf_pkg::SAMPLE_W-1:0] sample,
	output logic                                    ram_we,
	output logic      [AW-1:0]                      ram_waddr,
	output logic      [sdrf_pkg::SAMPLE_W-1:0]      ram_wdata,
	input  wire sdrf_pkg::q_stat_t                  q_stat,
	input  wire logic [AW-1:0]                      q_head_addr,
	output logic                                    push,
	output logic      [AW-1:0]                      push_addr,
	output sdrf_pkg::job_t                          push_job,
	input  wire logic                               back_busy,
	input  wire logic [AW-1:0]                      back_addr,
	output sdrf_pkg::geom_t                         geom,
	output logic      [sdrf_pkg::WEIGHT_W-1:0]      epsilon,
	output logic      [sdrf_pkg::WEIGHT_W-1:0]      threshold
);
	import sdrf_pkg::*;

	localparam int EW = (AW > 16 ? AW : 16) + 1;
	localparam logic [8:0] MX = 9'(MAX_X);
	localparam logic [8:0] MY = 9'(MAX_Y);
	localparam logic [8:0] MZ = 9'(MAX_Z);

	logic [DIM_W-1:0]  dim_x_q, dim_y_q, dim_z_q;
	logic [RANK_W-1:0] rank_q;
	logic [GW_W-1:0]   ghost_q;
	logic [WEIGHT_W-1:0] epsilon_q, threshold_q;
	logic [AW-1:0]     wr_q;
	logic [DIM_W-1:0]  pos_x_q, pos_y_q, pos_z_q;
	logic              fresh_q;

	logic [RANK_W-1:0]   rk;
	logic [1:0]          ti;
	logic [GW_W-1:0]     g;
	logic [DIM_W-1:0]    d [3];
	logic [DIM_W-1:0]    p [3];
	logic [DIM_W-1:0]    c [3];
	logic [STRIDE_W-1:0] s2;
	logic [STRIDE_W-1:0] stop;
	logic                active, last, accept, end_grid;
	logic [AW-1:0]       oldest;
	logic [EW-1:0]       lead, limit;
	logic                outstanding, safe;

	function automatic logic [DIM_W-1:0] clampd(input logic [DIM_W-1:0] v,
		input logic [8:0] mx);
		if (v == '0) begin
			return 7'd1;
		end
		if ({2'b00, v} > mx) begin
			return mx[DIM_W-1:0];
		end
		return v;
	endfunction

	// Effective geometry after clamping.
	assign rk   = (rank_q == '0) ? 2'd1 : rank_q;
	assign ti   = rk - 2'd1;
	assign g    = (ghost_q < 4'd2) ? 4'd2 : ghost_q;
	assign d[0] = clampd(dim_x_q, MX);
	assign d[1] = (rk >= 2'd2) ? clampd(dim_y_q, MY) : 7'd1;
	assign d[2] = (rk == 2'd3) ? clampd(dim_z_q, MZ) : 7'd1;
	assign s2   = STRIDE_W'(d[0]) * STRIDE_W'(d[1]);
	assign stop = (rk == 2'd1) ? 14'd1 : (rk == 2'd2) ? STRIDE_W'(d[0]) : s2;
	assign p[0] = pos_x_q;
	assign p[1] = pos_y_q;
	assign p[2] = pos_z_q;

	assign geom.rk   = rk;
	assign geom.s1   = d[0];
	assign geom.s2   = s2;
	assign geom.stop = stop;
	assign epsilon   = epsilon_q;
	assign threshold = threshold_q;

	// Classify the cell two top-axis strides behind the incoming sample.
	always_comb begin
		active = 1'b1;
		last   = 1'b1;
		for (int a = 0; a < 3; a++) begin
			c[a] = p[a];
		end
		c[ti] = p[ti] - 7'd2;
		for (int a = 0; a < 3; a++) begin
			if (2'(a) < rk) begin
				if (c[a] < 7'(g) ||
					({1'b0, c[a]} + 8'(g)) > {1'b0, d[a] - 7'd1}) begin
					active = 1'b0;
				end
				if (({1'b0, c[a]} + 8'(g)) != {1'b0, d[a] - 7'd1}) begin
					last = 1'b0;
				end
			end else begin
				c[a] = '0;
			end
		end
	end

	// A write must never land on a tap of a cell still waiting to be judged.
	assign outstanding = back_busy || !q_stat.empty;
	assign oldest      = back_busy ? back_addr : q_head_addr;
	assign lead  = (wr_q >= oldest) ? EW'(wr_q) - EW'(oldest)
		: EW'(wr_q) + EW'(DEPTH) - EW'(oldest);
	assign limit = EW'(DEPTH) - EW'({stop, 2'b00});
	assign safe  = lead < limit;

	assign in_stall = q_stat.full || (outstanding && !safe);
	assign accept   = in_valid && !in_stall;

	assign ram_we    = accept;
	assign ram_waddr = wr_q;
	assign ram_wdata = sample;

	assign push           = accept && (p[ti] >= 7'd2) && active;
	assign push_addr      = wr_q;
	assign push_job.cx    = c[0][COORD_W-1:0];
	assign push_job.cy    = c[1][COORD_W-1:0];
	assign push_job.cz    = c[2][COORD_W-1:0];
	assign push_job.last  = last;
	assign push_job.fresh = fresh_q;

	assign end_grid = ({1'b0, pos_x_q} + 8'd1 >= {1'b0, d[0]}) &&
		({1'b0, pos_y_q} + 8'd1 >= {1'b0, d[1]}) &&
		({1'b0, pos_z_q} + 8'd1 >= {1'b0, d[2]});

	// Registers, raster position and ring write slot.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dim_x_q     <= RST_DIM;
			dim_y_q     <= RST_DIM;
			dim_z_q     <= RST_DIM;
			rank_q      <= RST_RANK;
			ghost_q     <= RST_GHOST;
			epsilon_q   <= RST_EPSILON;
			threshold_q <= RST_THRESHOLD;
			wr_q        <= '0;
			pos_x_q     <= '0;
			pos_y_q     <= '0;
			pos_z_q     <= '0;
			fresh_q     <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DIM_X:     dim_x_q     <= cfg_data[DIM_W-1:0];
				REG_DIM_Y:     dim_y_q     <= cfg_data[DIM_W-1:0];
				REG_DIM_Z:     dim_z_q     <= cfg_data[DIM_W-1:0];
				REG_RANK:      rank_q      <= cfg_data[RANK_W-1:0];
				REG_GHOST:     ghost_q     <= cfg_data[GW_W-1:0];
				REG_EPSILON:   epsilon_q   <= cfg_data;
				REG_THRESHOLD: threshold_q <= cfg_data;
				default: ;
			endcase
			// A geometry change starts a new pass.
			if (cfg_index inside {REG_DIM_X, REG_DIM_Y, REG_DIM_Z, REG_RANK, REG_GHOST}) begin
				pos_x_q <= '0;
				pos_y_q <= '0;
				pos_z_q <= '0;
				fresh_q <= 1'b1;
			end
		end else if (accept) begin
			wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (end_grid) begin
				fresh_q <= 1'b1;
			end else if (push) begin
				fresh_q <= 1'b0;
			end
			if ({1'b0, pos_x_q} + 8'd1 < {1'b0, d[0]}) begin
				pos_x_q <= pos_x_q + 7'd1;
			end else begin
				pos_x_q <= '0;
				if ({1'b0, pos_y_q} + 8'd1 < {1'b0, d[1]}) begin
					pos_y_q <= pos_y_q + 7'd1;
				end else begin
					pos_y_q <= '0;
					if ({1'b0, pos_z_q} + 8'd1 < {1'b0, d[2]}) begin
						pos_z_q <= pos_z_q + 7'd1;
					end else begin
						pos_z_q <= '0;
					end
				end
			end
		end
	end

endmodule
`default_nettype wire

### hdl/sdrf_back.sv
`default_nettype none
module sdrf_back #(
	parameter int MAX_X = 64,
	parameter int MAX_Y = 64,
	localparam int DEPTH = 4 * MAX_X * MAX_Y + 1,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire sdrf_pkg::geom_t               geom,
	input  wire logic [sdrf_pkg::WEIGHT_W-1:0] epsilon,
	input  wire logic [sdrf_pkg::WEIGHT_W-1:0] threshold,
	input  wire sdrf_pkg::q_stat_t             q_stat,
	output logic                               pop,
	input  wire logic [AW-1:0]                 q_addr,
	input  wire sdrf_pkg::job_t                q_job,
	output logic      [AW-1:0]                 ram_raddr,
	input  wire logic [sdrf_pkg::SAMPLE_W-1:0] ram_rdata,
	output logic                               busy,
	output logic      [AW-1:0]                 cur_addr,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic                               flag,
	output logic      [sdrf_pkg::COORD_W-1:0]  cell_x,
	output logic      [sdrf_pkg::COORD_W-1:0]  cell_y,
	output logic      [sdrf_pkg::COORD_W-1:0]  cell_z,
	output logic      [sdrf_pkg::COUNT_W-1:0]  flagged_count,
	output logic                               last_cell
);
	import sdrf_pkg::*;

	localparam int EW = (AW > 16 ? AW : 16) + 1;

	typedef enum logic [2:0] {
		S_IDLE, S_READ, S_DRAIN, S_THR, S_LO, S_HI, S_SUM, S_DONE
	} state_t;

	// Tap order within one axis pair.
	typedef enum logic [2:0] {
		TAP_F0, TAP_FP, TAP_FM, TAP_PP, TAP_PM, TAP_MP, TAP_MM
	} tap_t;

	state_t      state_q;
	tap_t        t_q;
	logic [1:0]  k_q, l_q;
	logic [1:0]  lim;
	logic        end_tap;
	job_t        job_q;
	logic [AW-1:0] w_q;
	logic [COUNT_W-1:0] cnt_q, cnt_next;

	logic [STRIDE_W-1:0]  sk, sl;
	logic signed [16:0]   sks, sls, off, m17;
	logic [15:0]          m;
	logic [EW-1:0]        we_x, me_x, addr_x;

	logic                 rv_s1, rend_s1;
	tap_t                 rt_s1;
	logic signed [SAMPLE_W-1:0] f0_q, fp_q, fm_q, pp_q, pm_q, mp_q, mm_c;

	logic                 v_s2, end_s2;
	logic signed [25:0]   dd_s2;
	logic [25:0]          sa_s2, am_s2;
	logic signed [25:0]   dd_c;
	logic [25:0]          sa_c, am_c;

	logic                 v_s3, end_s3;
	logic [50:0]          dd2_s3;
	logic [29:0]          b16_s3;
	logic signed [51:0]   ddsq_c;
	logic [41:0]          es_c, bn_c;

	logic                 v_s4, end_s4;
	logic [50:0]          dd2_s4;
	logic [59:0]          b2_s4;

	logic [53:0]          top_q;
	logic [63:0]          bot_q;
	logic [31:0]          thr2_q;
	logic [63:0]          plo_q, phi_q;
	logic [95:0]          prod_q;
	logic                 flag_c;

	function automatic logic [STRIDE_W-1:0] strd(input logic [1:0] ax, input geom_t gm);
		case (ax)
			2'd0:    return 14'd1;
			2'd1:    return STRIDE_W'(gm.s1);
			default: return gm.s2;
		endcase
	endfunction

	function automatic logic [24:0] mag(input logic signed [24:0] v);
		return v[24] ? 25'(-v) : 25'(v);
	endfunction

	assign lim      = geom.rk - 2'd1;
	assign end_tap  = (t_q == TAP_MM) && (l_q == lim) && (k_q == lim);
	assign pop      = (state_q == S_IDLE) && !q_stat.empty;
	assign busy     = (state_q != S_IDLE);
	assign cur_addr = w_q;

	// Tap address: distance back from the newest sample of the job.
	assign sk  = strd(k_q, geom);
	assign sl  = strd(l_q, geom);
	assign sks = signed'({3'b000, sk});
	assign sls = signed'({3'b000, sl});
	always_comb begin
		case (t_q)
			TAP_F0:  off = '0;
			TAP_FP:  off = sks;
			TAP_FM:  off = -sks;
			TAP_PP:  off = sks + sls;
			TAP_PM:  off = sks - sls;
			TAP_MP:  off = sls - sks;
			TAP_MM:  off = -sks - sls;
			default: off = '0;
		endcase
	end
	assign m17    = signed'({2'b00, geom.stop, 1'b0}) - off;
	assign m      = m17[15:0];
	assign we_x   = EW'(w_q);
	assign me_x   = EW'(m);
	assign addr_x = (we_x >= me_x) ? we_x - me_x : we_x + EW'(DEPTH) - me_x;
	assign ram_raddr = addr_x[AW-1:0];

	// Pair terms from the seven taps.
	assign mm_c = signed'(ram_rdata);
	assign dd_c = 26'(pp_q) - 26'(pm_q) - 26'(mp_q) + 26'(mm_c);
	assign sa_c = 26'(mag(25'(pp_q))) + 26'(mag(25'(pm_q))) +
		26'(mag(25'(mp_q))) + 26'(mag(25'(mm_c)));
	assign am_c = 26'(mag(25'(fp_q) - 25'(f0_q))) + 26'(mag(25'(f0_q) - 25'(fm_q)));

	assign ddsq_c = dd_s2 * dd_s2;
	assign es_c   = {26'b0, epsilon} * {16'b0, sa_s2};
	assign bn_c   = {1'b0, am_s2, 15'b0} + es_c;

	// Final compare: top * 2^29 against threshold^2 * bottom.
	assign flag_c   = {13'b0, top_q, 29'b0} > prod_q;
	assign cnt_next = (job_q.fresh ? '0 : cnt_q) + COUNT_W'(flag_c);

	// Valid bits of the arithmetic pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rv_s1 <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
		end else begin
			rv_s1 <= (state_q == S_READ);
			v_s2  <= rv_s1 && (rt_s1 == TAP_MM);
			v_s3  <= v_s2;
			v_s4  <= v_s3;
		end
	end

	// Arithmetic pipeline payload and accumulators.
	always_ff @(posedge clk) begin
		rt_s1   <= t_q;
		rend_s1 <= end_tap;
		if (rv_s1) begin
			case (rt_s1)
				TAP_F0:  f0_q <= signed'(ram_rdata);
				TAP_FP:  fp_q <= signed'(ram_rdata);
				TAP_FM:  fm_q <= signed'(ram_rdata);
				TAP_PP:  pp_q <= signed'(ram_rdata);
				TAP_PM:  pm_q <= signed'(ram_rdata);
				TAP_MP:  mp_q <= signed'(ram_rdata);
				default: ;
			endcase
		end
		dd_s2  <= dd_c;
		sa_s2  <= sa_c;
		am_s2  <= am_c;
		end_s2 <= rend_s1;
		dd2_s3 <= ddsq_c[50:0];
		b16_s3 <= bn_c[41:12];
		end_s3 <= end_s2;
		dd2_s4 <= dd2_s3;
		b2_s4  <= 60'(b16_s3) * 60'(b16_s3);
		end_s4 <= end_s3;
		if (pop) begin
			top_q <= '0;
			bot_q <= '0;
			w_q   <= q_addr;
			job_q <= q_job;
		end else if (v_s4) begin
			top_q <= top_q + 54'(dd2_s4);
			bot_q <= bot_q + 64'(b2_s4);
		end
		thr2_q <= 32'(threshold) * 32'(threshold);
		plo_q  <= 64'(thr2_q) * 64'(bot_q[31:0]);
		phi_q  <= 64'(thr2_q) * 64'(bot_q[63:32]);
		prod_q <= {phi_q, 32'b0} + {32'b0, plo_q};
	end

	// Sequencer over axis pairs and taps, and the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			t_q           <= TAP_F0;
			k_q           <= '0;
			l_q           <= '0;
			out_valid     <= 1'b0;
			cnt_q         <= '0;
			flag          <= 1'b0;
			cell_x        <= '0;
			cell_y        <= '0;
			cell_z        <= '0;
			flagged_count <= '0;
			last_cell     <= 1'b0;
		end else begin
			// A taken result empties the register unless a new one replaces it.
			if (out_valid && !out_stall && state_q != S_DONE) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (!q_stat.empty) begin
						state_q <= S_READ;
						t_q     <= TAP_F0;
						k_q     <= '0;
						l_q     <= '0;
					end
				end
				S_READ: begin
					if (t_q == TAP_MM) begin
						t_q <= TAP_F0;
						if (l_q == lim) begin
							l_q <= '0;
							if (k_q == lim) begin
								state_q <= S_DRAIN;
							end else begin
								k_q <= k_q + 2'd1;
							end
						end else begin
							l_q <= l_q + 2'd1;
						end
					end else begin
						t_q <= tap_t'(t_q + 3'd1);
					end
				end
				S_DRAIN: begin
					if (v_s4 && end_s4) begin
						state_q <= S_THR;
					end
				end
				S_THR: state_q <= S_LO;
				S_LO:  state_q <= S_HI;
				S_HI:  state_q <= S_SUM;
				S_SUM: state_q <= S_DONE;
				S_DONE: begin
					if (!out_valid || !out_stall) begin
						out_valid     <= 1'b1;
						flag          <= flag_c;
						cell_x        <= job_q.cx;
						cell_y        <= job_q.cy;
						cell_z        <= job_q.cz;
						flagged_count <= cnt_next;
						last_cell     <= job_q.last;
						cnt_q         <= cnt_next;
						state_q       <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

### hdl/second_derivative_refinement_flagger_unit.sv
`default_nettype none
// Second-derivative refinement flagger.
// Samples of one field enter on the input channel (in_valid, in_stall, sample)
// in raster order, x fastest. Each transfer is written into a ring of four
// planes plus one sample. When the transfer completes the stencil of an
// active cell, a job goes into a four-entry queue; the back part reads the
// taps one per cycle through the single read port of the ring and produces
// one result transfer (flag, cell coordinates, running count, last marker).
// Per active cell the back part needs 7 * rank * rank tap reads, then the
// arithmetic and the final compare. Ghost cells are written to the ring but
// make no job. The tap read port sets the throughput.
// Input is held off when the queue is full or when the next write would
// overwrite a tap of a cell not yet judged. A stalled receiver holds the
// result register; the back part then waits before its next result, and the
// queue keeps the input side running. Reset puts all positions, counts and
// registers to their defaults; the sample ring is not cleared.
module second_derivative_refinement_flagger_unit #(
	parameter int MAX_X = sdrf_pkg::DEF_MAX_X,
	parameter int MAX_Y = sdrf_pkg::DEF_MAX_Y,
	parameter int MAX_Z = sdrf_pkg::DEF_MAX_Z
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cfg_we,
	input  wire logic [sdrf_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [sdrf_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  wire logic                                 in_valid,
	output logic                                      in_stall,
	input  wire logic signed [sdrf_pkg::SAMPLE_W-1:0] sample,
	output logic                                      out_valid,
	input  wire logic                                 out_stall,
	output logic                                      flag,
	output logic      [sdrf_pkg::COORD_W-1:0]         cell_x,
	output logic      [sdrf_pkg::COORD_W-1:0]         cell_y,
	output logic      [sdrf_pkg::COORD_W-1:0]         cell_z,
	output logic      [sdrf_pkg::COUNT_W-1:0]         flagged_count,
	output logic                                      last_cell
);
	import sdrf_pkg::*;

	localparam int DEPTH = 4 * MAX_X * MAX_Y + 1;
	localparam int AW    = $clog2(DEPTH);
	localparam int QW    = AW + $bits(job_t);

	logic                ram_we;
	logic [AW-1:0]       ram_waddr, ram_raddr;
	logic [SAMPLE_W-1:0] ram_wdata, ram_rdata;
	q_stat_t             q_stat;
	logic                q_push, q_pop;
	logic [AW-1:0]       push_addr;
	job_t                push_job;
	logic [QW-1:0]       q_head;
	logic                back_busy;
	logic [AW-1:0]       back_addr;
	geom_t               geom;
	logic [WEIGHT_W-1:0] epsilon, threshold;

	sdrf_front #(.MAX_X(MAX_X), .MAX_Y(MAX_Y), .MAX_Z(MAX_Z)) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.sample      (sample),
		.ram_we      (ram_we),
		.ram_waddr   (ram_waddr),
		.ram_wdata   (ram_wdata),
		.q_stat      (q_stat),
		.q_head_addr (q_head[QW-1 -: AW]),
		.push        (q_push),
		.push_addr   (push_addr),
		.push_job    (push_job),
		.back_busy   (back_busy),
		.back_addr   (back_addr),
		.geom        (geom),
		.epsilon     (epsilon),
		.threshold   (threshold)
	);

	sdrf_queue #(.W(QW)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data ({push_addr, push_job}),
		.pop       (q_pop),
		.head      (q_head),
		.stat      (q_stat)
	);

	sdrf_ram #(.WIDTH(SAMPLE_W), .DEPTH(DEPTH)) u_ring (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	sdrf_back #(.MAX_X(MAX_X), .MAX_Y(MAX_Y)) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.geom          (geom),
		.epsilon       (epsilon),
		.threshold     (threshold),
		.q_stat        (q_stat),
		.pop           (q_pop),
		.q_addr        (q_head[QW-1 -: AW]),
		.q_job         (job_t'(q_head[$bits(job_t)-1:0])),
		.ram_raddr     (ram_raddr),
		.ram_rdata     (ram_rdata),
		.busy          (back_busy),
		.cur_addr      (back_addr),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.flag          (flag),
		.cell_x        (cell_x),
		.cell_y        (cell_y),
		.cell_z        (cell_z),
		.flagged_count (flagged_count),
		.last_cell     (last_cell)
	);

	// The job queue never takes a job when full.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.full |-> !q_push)
		else $error("job queue overflow");

	// The back part only takes a job that is there.
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_stat.empty)
		else $error("job queue underflow");

	// While the back part works on a job, the ring write slot never reaches it.
	a_ring_guard: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && back_busy) |-> (ram_waddr != back_addr))
		else $error("ring write over a pending job");

endmodule
`default_nettype wire
